>>> rtl/pic_pkg.sv
// Shared types, field widths and instruction codes for the programmable interval clock.
// No dependencies; every other file in rtl/ imports this package.
package pic_pkg;

    // Field widths
    localparam int unsigned WORD_W   = 12;
    localparam int unsigned CMD_W    = 3;
    localparam int unsigned FLAGS_W  = 7;
    localparam int unsigned S_DATA_W = 16;  // command and data_in, padded to whole bytes
    localparam int unsigned M_DATA_W = 24;  // all result fields, padded to whole bytes

    // Bit positions in the flag word
    localparam int unsigned FLAG_SEQ       = 0;
    localparam int unsigned FLAG_INT_FUND  = 1;
    localparam int unsigned FLAG_INT_BASE  = 2;
    localparam int unsigned FLAG_INT_MULT  = 3;
    localparam int unsigned FLAG_BASE      = 4;
    localparam int unsigned FLAG_MULT      = 5;
    localparam int unsigned FLAG_FUND      = 6;

    localparam logic [FLAGS_W-1:0] FLAGS_RESET = 7'h02;  // interrupt on fundamental only
    localparam logic [FLAGS_W-1:0] FLAGS_LOW6  = 7'h3F;  // everything but the fundamental flag

    // Clock modes
    localparam logic MODE_BASIC = 1'b0;
    localparam logic MODE_PROG  = 1'b1;

    // Basic mode function codes
    localparam logic [CMD_W-1:0] BAS_INT_ON     = 3'd1;
    localparam logic [CMD_W-1:0] BAS_INT_OFF    = 3'd2;
    localparam logic [CMD_W-1:0] BAS_SKIP_CLEAR = 3'd3;
    localparam logic [CMD_W-1:0] BAS_SET_ENABLE = 3'd5;
    localparam logic [CMD_W-1:0] BAS_CLR_ENABLE = 3'd6;
    localparam logic [CMD_W-1:0] BAS_SKIP_DONE  = 3'd7;

    // Programmable mode function codes
    localparam logic [CMD_W-1:0] PRG_SET_FLAGS  = 3'd0;
    localparam logic [CMD_W-1:0] PRG_INT_ON     = 3'd1;
    localparam logic [CMD_W-1:0] PRG_INT_OFF    = 3'd2;
    localparam logic [CMD_W-1:0] PRG_SKIP_DONE  = 3'd3;
    localparam logic [CMD_W-1:0] PRG_LOAD_BASE  = 3'd4;
    localparam logic [CMD_W-1:0] PRG_LOAD_MULT  = 3'd5;
    localparam logic [CMD_W-1:0] PRG_RANDOM     = 3'd6;
    localparam logic [CMD_W-1:0] PRG_READ_FLAGS = 3'd7;

    // Architectural state of the clock
    typedef struct packed {
        logic [FLAGS_W-1:0] flags;
        logic [WORD_W-1:0]  base_cnt;
        logic [WORD_W-1:0]  mult_cnt;
        logic [WORD_W-1:0]  base_rld;
        logic [WORD_W-1:0]  mult_rld;
        logic               done;
        logic               enable;
    } pic_state_t;

    // Per-word answer of the instruction decoder
    typedef struct packed {
        logic [WORD_W-1:0] data_out;
        logic              skip;
    } pic_result_t;

endpackage

>>> rtl/programmable_interval_clock_top.sv
// Top level of the programmable interval clock: stream ports, input and output registers.
// Depends on pic_pkg and on pic_core for the per-word logic.
//
//  Channel | Ports                          | Word contents
//  --------+--------------------------------+---------------------------------------------
//  input   | s_tvalid s_tready s_tdata s_tuser | tick or instruction with accumulator word
//  result  | m_tvalid m_tready m_tdata      | returned word, skip, done, enable, irq, flags
//  config  | cfg_valid cfg_ready cfg_data   | clock mode, basic or programmable
//
// Each word is held in the input register while the core logic works on it, and its result
// word is registered into the output register and presented on m_tvalid; one word per cycle
// is sustained while m_tready stays high. The output register stalls on m_tready and the input
// register holds a word behind it. Reset is synchronous on aresetn low; the configuration
// port is always ready.
module programmable_interval_clock_top (
    input  logic                           aclk,
    input  logic                           aresetn,
    // Input words
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [pic_pkg::S_DATA_W-1:0]   s_tdata,   // [2:0] command, [14:3] data_in, [15] zero
    input  logic                           s_tuser,   // [0] is_tick
    // Result words
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [pic_pkg::M_DATA_W-1:0]   m_tdata,   // [11:0] data_out, [12] skip,
                                                      // [13] done_flag, [14] interrupt_enabled,
                                                      // [15] interrupt_request,
                                                      // [22:16] status_flags, [23] zero
    // Configuration
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic                           cfg_data   // clock_mode
);
    import pic_pkg::*;

    logic               in_valid_reg;
    logic               in_valid_next;
    logic               in_tick_reg;
    logic [CMD_W-1:0]   in_cmd_reg;
    logic [WORD_W-1:0]  in_data_reg;
    logic               mode_reg;
    pic_state_t         state_reg;
    pic_state_t         state_next;
    pic_result_t        result;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [M_DATA_W-1:0] out_data_reg;
    logic [M_DATA_W-1:0] out_data_next;
    logic               s_accept;
    logic               advance;

    // Handshake: the core moves a word when the output register is free or draining
    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign in_valid_next  = s_accept || (in_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && !m_tready);

    // Per-word logic
    pic_core u_core (
        .clock_mode (mode_reg),
        .is_tick    (in_tick_reg),
        .command    (in_cmd_reg),
        .data_in    (in_data_reg),
        .state_cur  (state_reg),
        .state_new  (state_next),
        .result     (result)
    );

    // Pack the result word from the updated state
    assign out_data_next = {1'b0, state_next.flags,
                            state_next.done & state_next.enable,
                            state_next.enable, state_next.done,
                            result.skip, result.data_out};

    // Control registers and clock state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg       <= 1'b0;
            out_valid_reg      <= 1'b0;
            mode_reg           <= MODE_BASIC;
            state_reg.flags    <= FLAGS_RESET;
            state_reg.base_cnt <= '0;
            state_reg.mult_cnt <= '0;
            state_reg.base_rld <= '0;
            state_reg.mult_rld <= '0;
            state_reg.done     <= 1'b0;
            state_reg.enable   <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid) begin
                mode_reg <= cfg_data;
            end
            if (advance) begin
                state_reg <= state_next;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_tick_reg <= s_tuser;
            in_cmd_reg  <= s_tdata[CMD_W-1:0];
            in_data_reg <= s_tdata[CMD_W+WORD_W-1:CMD_W];
        end
        if (advance) begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

>>> rtl/pic_core.sv
// Next-state and result logic for one tick or instruction of the interval clock.
// Depends on pic_pkg for the state type, flag positions and function codes.
module pic_core (
    input  logic                         clock_mode,
    input  logic                         is_tick,
    input  logic [pic_pkg::CMD_W-1:0]    command,
    input  logic [pic_pkg::WORD_W-1:0]   data_in,
    input  pic_pkg::pic_state_t          state_cur,
    output pic_pkg::pic_state_t          state_new,
    output pic_pkg::pic_result_t         result
);
    import pic_pkg::*;

    logic base_zero;
    logic mult_zero;
    logic base_one;
    logic mult_one;
    logic [WORD_W-1:0] base_dec;
    logic [WORD_W-1:0] mult_dec;

    // Counter decrements and zero tests shared by both counter forms
    assign base_zero = (state_cur.base_cnt == '0);
    assign mult_zero = (state_cur.mult_cnt == '0);
    assign base_one  = (state_cur.base_cnt == WORD_W'(1));
    assign mult_one  = (state_cur.mult_cnt == WORD_W'(1));
    assign base_dec  = state_cur.base_cnt - WORD_W'(1);
    assign mult_dec  = state_cur.mult_cnt - WORD_W'(1);

    // One item: a tick sets the fundamental flag or steps the counters, an instruction is decoded by mode
    always_comb begin
        state_new       = state_cur;
        result.data_out = '0;
        result.skip     = 1'b0;

        if (is_tick) begin
            if (clock_mode == MODE_BASIC) begin
                state_new.flags[FLAG_FUND] = 1'b1;
                state_new.done             = 1'b1;
            end else if (state_cur.flags[FLAG_INT_FUND]) begin
                state_new.flags[FLAG_FUND] = 1'b1;
                state_new.done             = 1'b1;
            end else if (state_cur.flags[FLAG_SEQ]) begin
                // Sequential form: base runs out, then the multiplier runs out
                if (base_zero) begin
                    if (mult_zero) begin
                        state_new.base_cnt = state_cur.base_rld;
                        state_new.mult_cnt = state_cur.mult_rld;
                    end else begin
                        state_new.mult_cnt = mult_dec;
                        if (mult_one && state_cur.flags[FLAG_INT_MULT]) begin
                            state_new.flags[FLAG_MULT] = 1'b1;
                            state_new.done             = 1'b1;
                        end
                    end
                end else begin
                    state_new.base_cnt = base_dec;
                    if (base_one && state_cur.flags[FLAG_INT_BASE]) begin
                        state_new.flags[FLAG_BASE] = 1'b1;
                        state_new.done             = 1'b1;
                    end
                end
            end else begin
                // Nested form: every base period steps the multiplier once
                if (base_zero) begin
                    if (state_cur.flags[FLAG_INT_BASE]) begin
                        state_new.flags[FLAG_BASE] = 1'b1;
                        state_new.done             = 1'b1;
                    end
                    if (mult_zero) begin
                        if (state_cur.flags[FLAG_INT_MULT]) begin
                            state_new.flags[FLAG_MULT] = 1'b1;
                            state_new.done             = 1'b1;
                        end
                        state_new.mult_cnt = state_cur.mult_rld;
                    end else begin
                        state_new.mult_cnt = mult_dec;
                    end
                    state_new.base_cnt = state_cur.base_rld;
                end else begin
                    state_new.base_cnt = base_dec;
                end
            end
        end else if (clock_mode == MODE_BASIC) begin
            result.data_out = data_in;
            case (command)
                BAS_INT_ON: begin
                    state_new.enable = 1'b1;
                end
                BAS_INT_OFF, BAS_CLR_ENABLE: begin
                    state_new.enable = 1'b0;
                end
                BAS_SKIP_CLEAR: begin
                    if (state_cur.done) begin
                        state_new.enable = 1'b0;
                        state_new.done   = 1'b0;
                        result.skip      = 1'b1;
                    end
                end
                BAS_SET_ENABLE: begin
                    if (data_in[0]) begin
                        state_new.enable = 1'b1;
                    end else begin
                        state_new.enable = 1'b0;
                        state_new.done   = 1'b0;
                    end
                end
                BAS_SKIP_DONE: begin
                    result.skip = state_cur.done;
                end
                default: begin
                end
            endcase
        end else begin
            result.data_out = data_in;
            case (command)
                PRG_SET_FLAGS: begin
                    state_new.flags = data_in[FLAGS_W-1:0] & FLAGS_LOW6;
                end
                PRG_INT_ON: begin
                    state_new.enable = 1'b1;
                end
                PRG_INT_OFF: begin
                    state_new.enable = 1'b0;
                end
                PRG_SKIP_DONE: begin
                    if (state_cur.done) begin
                        state_new.done = 1'b0;
                        result.skip    = 1'b1;
                    end
                end
                PRG_LOAD_BASE: begin
                    result.data_out    = state_cur.base_rld;
                    state_new.base_rld = data_in;
                    state_new.base_cnt = data_in;
                end
                PRG_LOAD_MULT: begin
                    result.data_out    = state_cur.mult_rld;
                    state_new.mult_rld = data_in;
                    state_new.mult_cnt = data_in;
                end
                PRG_RANDOM: begin
                end
                PRG_READ_FLAGS: begin
                    // Read the flag word, then drop the fundamental flag
                    result.data_out = WORD_W'(state_cur.flags);
                    state_new.flags = state_cur.flags & FLAGS_LOW6;
                end
                default: begin
                end
            endcase
        end
    end

endmodule

>>> verif/tb_programmable_interval_clock_top.sv
// Self-checking testbench for programmable_interval_clock_top: directed and random words
// in both clock modes, checked against a cycle-free predictor held in a scoreboard class.
// Depends on rtl/pic_pkg.sv and rtl/programmable_interval_clock_top.sv.
`timescale 1ns / 1ps

module tb_programmable_interval_clock_top;
    import pic_pkg::*;

    // One result word, fields from the top bit down to bit 0 of m_tdata.
    typedef struct packed {
        logic [FLAGS_W-1:0] status_flags;
        logic               interrupt_request;
        logic               interrupt_enabled;
        logic               done_flag;
        logic               skip;
        logic [WORD_W-1:0]  data_out;
    } clock_result_t;

    // Clock state model plus the queue of result words still owed by the block.
    class clock_scoreboard;
        logic               mode;
        logic [FLAGS_W-1:0] flags;
        logic [WORD_W-1:0]  base_cnt;
        logic [WORD_W-1:0]  mult_cnt;
        logic [WORD_W-1:0]  base_rld;
        logic [WORD_W-1:0]  mult_rld;
        logic               done;
        logic               enable;
        clock_result_t      owed_q[$];
        int unsigned        errors;

        function void reset_state();
            mode     = MODE_BASIC;
            flags    = FLAGS_RESET;
            base_cnt = '0;
            mult_cnt = '0;
            base_rld = '0;
            mult_rld = '0;
            done     = 1'b0;
            enable   = 1'b0;
            owed_q.delete();
            errors   = 0;
        endfunction

        function void set_mode(logic m);
            mode = m;
        endfunction

        function int unsigned pending();
            return owed_q.size();
        endfunction

        // An event sets its flag bit and the device done flag.
        function void post_event(int unsigned pos);
            flags[pos] = 1'b1;
            done       = 1'b1;
        endfunction

        // Tick in programmable mode: fundamental flag, or one step of the counter pair.
        function void counter_tick();
            if (flags[FLAG_INT_FUND]) begin
                post_event(FLAG_FUND);
            end else if (flags[FLAG_SEQ]) begin
                // Sequential form: base runs out first, then the multiplier, then both reload.
                if (base_cnt == '0) begin
                    if (mult_cnt == '0) begin
                        base_cnt = base_rld;
                        mult_cnt = mult_rld;
                    end else begin
                        mult_cnt = mult_cnt - 1'b1;
                        if (mult_cnt == '0 && flags[FLAG_INT_MULT])
                            post_event(FLAG_MULT);
                    end
                end else begin
                    base_cnt = base_cnt - 1'b1;
                    if (base_cnt == '0 && flags[FLAG_INT_BASE])
                        post_event(FLAG_BASE);
                end
            end else begin
                // Nested form: every base wrap steps the multiplier once.
                if (base_cnt == '0) begin
                    if (flags[FLAG_INT_BASE])
                        post_event(FLAG_BASE);
                    if (mult_cnt == '0) begin
                        if (flags[FLAG_INT_MULT])
                            post_event(FLAG_MULT);
                        mult_cnt = mult_rld;
                    end else begin
                        mult_cnt = mult_cnt - 1'b1;
                    end
                    base_cnt = base_rld;
                end else begin
                    base_cnt = base_cnt - 1'b1;
                end
            end
        endfunction

        // Works out the result of one accepted input word and queues it.
        function void note_word(logic tick, logic [CMD_W-1:0] cmd, logic [WORD_W-1:0] data);
            clock_result_t res;
            logic [WORD_W-1:0] ret;
            logic sk;
            ret = data;
            sk  = 1'b0;
            if (tick) begin
                ret = '0;
                if (mode == MODE_BASIC)
                    post_event(FLAG_FUND);
                else
                    counter_tick();
            end else if (mode == MODE_BASIC) begin
                case (cmd)
                    BAS_INT_ON:     enable = 1'b1;
                    BAS_INT_OFF:    enable = 1'b0;
                    BAS_SKIP_CLEAR: begin
                        if (done) begin
                            enable = 1'b0;
                            done   = 1'b0;
                            sk     = 1'b1;
                        end
                    end
                    BAS_SET_ENABLE: begin
                        if (data[0]) begin
                            enable = 1'b1;
                        end else begin
                            enable = 1'b0;
                            done   = 1'b0;
                        end
                    end
                    BAS_CLR_ENABLE: enable = 1'b0;
                    BAS_SKIP_DONE:  sk = done;
                    default: ;
                endcase
            end else begin
                case (cmd)
                    PRG_SET_FLAGS:  flags = data[FLAGS_W-1:0] & FLAGS_LOW6;
                    PRG_INT_ON:     enable = 1'b1;
                    PRG_INT_OFF:    enable = 1'b0;
                    PRG_SKIP_DONE: begin
                        if (done) begin
                            done = 1'b0;
                            sk   = 1'b1;
                        end
                    end
                    PRG_LOAD_BASE: begin
                        ret      = base_rld;
                        base_rld = data;
                        base_cnt = data;
                    end
                    PRG_LOAD_MULT: begin
                        ret      = mult_rld;
                        mult_rld = data;
                        mult_cnt = data;
                    end
                    PRG_RANDOM: ;
                    PRG_READ_FLAGS: begin
                        ret   = WORD_W'(flags);
                        flags = flags & FLAGS_LOW6;
                    end
                    default: ;
                endcase
            end
            res.data_out          = ret;
            res.skip              = sk;
            res.done_flag         = done;
            res.interrupt_enabled = enable;
            res.interrupt_request = done & enable;
            res.status_flags      = flags;
            owed_q.push_back(res);
        endfunction

        function void field_diff(string label, int unsigned want, int unsigned got);
            if (want != got) begin
                $display("%0t: %s mismatch, expected %0h actual %0h", $time, label, want, got);
                errors++;
            end
        endfunction

        // Compares one accepted result word with the oldest owed result.
        function void check_result(logic [M_DATA_W-1:0] word);
            clock_result_t want;
            clock_result_t got;
            if (owed_q.size() == 0) begin
                $display("%0t: unexpected result word, expected none actual %h", $time, word);
                errors++;
                return;
            end
            want = owed_q.pop_front();
            got  = clock_result_t'(word[$bits(clock_result_t)-1:0]);
            field_diff("data_out", want.data_out, got.data_out);
            field_diff("skip", want.skip, got.skip);
            field_diff("done_flag", want.done_flag, got.done_flag);
            field_diff("interrupt_enabled", want.interrupt_enabled, got.interrupt_enabled);
            field_diff("interrupt_request", want.interrupt_request, got.interrupt_request);
            field_diff("status_flags", want.status_flags, got.status_flags);
        endfunction
    endclass

    localparam int unsigned CYCLE_LIMIT = 400_000;

    // Basic mode leaves these two codes unused.
    localparam logic [CMD_W-1:0] BAS_SPARE_0 = 3'd0;
    localparam logic [CMD_W-1:0] BAS_SPARE_4 = 3'd4;

    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata   = '0;   // [2:0] command, [14:3] data_in, [15] zero
    logic                s_tuser   = 1'b0; // [0] is_tick
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;          // [11:0] data_out, [12] skip, [13] done_flag,
                                           // [14] interrupt_enabled, [15] interrupt_request,
                                           // [22:16] status_flags, [23] zero
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic                cfg_data  = 1'b0;

    clock_scoreboard sb;
    int unsigned     words_sent  = 0;
    int unsigned     send_idle   = 0;  // percent of cycles the sender holds off
    int unsigned     recv_stall  = 0;  // percent of cycles the receiver stalls
    int unsigned     cycle_count = 0;

    programmable_interval_clock_top u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #10 aclk = ~aclk;

    // Receiver back-pressure.
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall);
    end

    // Watch all three channels; results are checked before the new word is noted.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata);
            if (s_tvalid && s_tready)
                sb.note_word(s_tuser, s_tdata[CMD_W-1:0], s_tdata[CMD_W +: WORD_W]);
            if (cfg_valid && cfg_ready)
                sb.set_mode(cfg_data);
        end
    end

    // Run limit.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb_programmable_interval_clock_top NOT OK");
            $finish;
        end
    end

    // Sends one word, with a random hold-off first, and returns at the accepting edge.
    task automatic send_word(input logic tick, input logic [CMD_W-1:0] cmd,
                             input logic [WORD_W-1:0] data);
        while ($urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= tick;
        s_tdata  <= {1'b0, data, cmd};
        do @(posedge aclk); while (!s_tready);
        words_sent++;
    endtask

    // Stops sending and waits until every owed result has come back.
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_mode(input logic m);
        cfg_valid <= 1'b1;
        cfg_data  <= m;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Mostly counter programming followed by a run of ticks, with some loose noise words.
    task automatic run_prog_mix(input int unsigned count);
        int unsigned stop_at;
        int unsigned ticks;
        logic [WORD_W-1:0] w;
        stop_at = words_sent + count;
        while (words_sent < stop_at) begin
            if ($urandom_range(9) < 8) begin
                w = WORD_W'($urandom);
                if ($urandom_range(3) != 0)
                    w[FLAG_INT_FUND] = 1'b0;
                send_word(1'b0, PRG_SET_FLAGS, w);
                w = ($urandom_range(9) == 0) ? WORD_W'($urandom) : WORD_W'($urandom_range(5));
                send_word(1'b0, PRG_LOAD_BASE, w);
                send_word(1'b0, PRG_LOAD_MULT, WORD_W'($urandom_range(3)));
                ticks = $urandom_range(24, 4);
                repeat (ticks) begin
                    if ($urandom_range(5) == 0)
                        send_word(1'b0, CMD_W'($urandom), WORD_W'($urandom));
                    send_word(1'b1, CMD_W'($urandom), WORD_W'($urandom));
                end
                send_word(1'b0, PRG_READ_FLAGS, WORD_W'($urandom));
                send_word(1'b0, PRG_SKIP_DONE, WORD_W'($urandom));
            end else begin
                send_word(1'($urandom), CMD_W'($urandom), WORD_W'($urandom));
            end
        end
    endtask

    task automatic run_basic_mix(input int unsigned count);
        int unsigned stop_at;
        stop_at = words_sent + count;
        while (words_sent < stop_at)
            send_word($urandom_range(2) == 0, CMD_W'($urandom), WORD_W'($urandom));
    endtask

    initial begin
        sb = new;
        sb.reset_state();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        write_mode(MODE_BASIC);

        // Basic mode: spare codes, skips with done low and high, enable handling.
        send_word(1'b0, BAS_SPARE_0, 12'hFFF);
        send_word(1'b0, BAS_SPARE_4, 12'h000);
        send_word(1'b0, BAS_SKIP_DONE, 12'h555);
        send_word(1'b1, 3'd7, 12'hFFF);
        send_word(1'b0, BAS_SKIP_DONE, 12'hFFF);
        send_word(1'b0, BAS_INT_ON, 12'hAAA);
        send_word(1'b0, BAS_SKIP_CLEAR, 12'h001);
        send_word(1'b0, BAS_SKIP_CLEAR, 12'h002);
        send_word(1'b1, 3'd0, 12'h000);
        send_word(1'b0, BAS_SET_ENABLE, 12'h001);
        send_word(1'b0, BAS_SET_ENABLE, 12'hFFE);
        send_word(1'b0, BAS_INT_ON, 12'h000);
        send_word(1'b0, BAS_CLR_ENABLE, 12'h123);
        send_word(1'b0, BAS_INT_OFF, 12'hFFF);
        settle();

        // Programmable mode: fundamental flag, flag read-back, both counter forms.
        write_mode(MODE_PROG);
        send_word(1'b1, 3'd0, 12'h000);
        send_word(1'b0, PRG_READ_FLAGS, 12'h000);
        send_word(1'b0, PRG_SKIP_DONE, 12'hFFF);
        send_word(1'b0, PRG_SET_FLAGS, 12'hFC5);
        send_word(1'b0, PRG_LOAD_BASE, 12'h001);
        send_word(1'b0, PRG_LOAD_MULT, 12'h001);
        repeat (4) send_word(1'b1, 3'd5, 12'h000);
        send_word(1'b0, PRG_SET_FLAGS, 12'h00C);
        repeat (3) send_word(1'b1, 3'd2, 12'hFFF);
        send_word(1'b0, PRG_LOAD_BASE, 12'hFFF);
        send_word(1'b0, PRG_RANDOM, 12'hABC);
        send_word(1'b0, PRG_INT_ON, 12'h000);
        send_word(1'b0, PRG_INT_OFF, 12'h000);
        settle();

        // Random part: four idling patterns, each in both modes.
        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 46; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 46; end
                default: begin send_idle = 15; recv_stall = 15; end
            endcase
            write_mode(MODE_PROG);
            run_prog_mix(100);
            settle();
            write_mode(MODE_BASIC);
            run_basic_mix(60);
            settle();
        end

        repeat (10) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("tb_programmable_interval_clock_top OK");
        else
            $display("tb_programmable_interval_clock_top NOT OK");
        $finish;
    end

endmodule

>>> filelist.f
rtl/pic_pkg.sv
rtl/pic_core.sv
rtl/programmable_interval_clock_top.sv
verif/tb_programmable_interval_clock_top.sv
